/* design/cma_pkg.sv */
// Shared constants, command/status types and helper functions for the
// confusion matrix accumulator. No dependencies.
package cma_pkg;

  // Table geometry and counter width
  localparam int NUM_CLASSES = 16;
  localparam int COUNT_BITS  = 32;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int LABEL_W    = 8;
  localparam int OUT_W      = 32;
  localparam int ACC_W      = 14;
  localparam int SPAN_OUT_W = 5;
  localparam int STATUS_W   = 2;

  // Derived sizes
  localparam int LBL_W     = $clog2(NUM_CLASSES);
  localparam int CELLS     = NUM_CLASSES * NUM_CLASSES;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int SPAN_W    = $clog2(NUM_CLASSES + 1);
  localparam int RNG_W     = LABEL_W + 1;
  localparam int PROD_W    = COUNT_BITS + ACC_W;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  // Accuracy scale: hundredths of a percent
  localparam int PCT_SCALE = 100;
  localparam int ACC_SCALE = PCT_SCALE * PCT_SCALE;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // capture input word, start cell read
    logic exec;      // update table and counters, form result
    logic mul;       // load scaled correct count and shifted divisor
    logic div_step;  // one restoring division step
    logic push;      // load output register
  } cma_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              nonempty;
    logic              out_free;
  } cma_sts_t;

  // Saturating increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Clip a counter to the output field width
  function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_W-1:0] wide;
    wide = {{OUT_W{1'b0}}, v};
    return (wide > {{COUNT_BITS{1'b0}}, {OUT_W{1'b1}}}) ? '1 : wide[OUT_W-1:0];
  endfunction

endpackage

/* design/cma_if.sv */
// Valid/ready channel interfaces for input and result words.
// Depends on cma_pkg for field widths.
interface cma_in_if;
  import cma_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [LABEL_W-1:0] truth_label;
  logic [LABEL_W-1:0] predicted_label;
  modport source (output valid, kind, truth_label, predicted_label, input ready);
  modport sink   (input valid, kind, truth_label, predicted_label, output ready);
endinterface

interface cma_out_if;
  import cma_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OUT_W-1:0]      count_value;
  logic [OUT_W-1:0]      total_samples;
  logic [ACC_W-1:0]      accuracy_hundredths;
  logic [SPAN_OUT_W-1:0] classes_seen;
  logic [STATUS_W-1:0]   status;
  modport source (output valid, count_value, total_samples, accuracy_hundredths,
                  classes_seen, status, input ready);
  modport sink   (input valid, count_value, total_samples, accuracy_hundredths,
                  classes_seen, status, output ready);
endinterface

/* design/cma_ctrl.sv */
// Sequencing state machine for the confusion matrix accumulator.
// Depends on cma_pkg for the command and status structs.
module cma_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cma_pkg::cma_sts_t sts,
  output cma_pkg::cma_cmd_t cmd
);
  import cma_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.kind == KIND_SUMMARY && sts.nonempty) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = DIV_CNT_W'(ACC_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // An accepted word always goes to execution next
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_EXEC)
    else $error("accepted word did not enter execution");

  // Last division step hands over to result delivery
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> state_r == S_DONE)
    else $error("division did not end after its last step");

  // Result is only pushed into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("push into an occupied output register");

endmodule

/* design/cma_dp.sv */
// Datapath: counter table memory, totals, restoring divider and output register.
// Depends on cma_pkg and the cma_out_if interface.
module cma_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cma_pkg::cma_cmd_t              cmd,
  output cma_pkg::cma_sts_t              sts,
  input  logic [cma_pkg::KIND_W-1:0]     in_kind,
  input  logic [cma_pkg::LABEL_W-1:0]    in_truth,
  input  logic [cma_pkg::LABEL_W-1:0]    in_pred,
  cma_out_if.source                      out_word
);
  import cma_pkg::*;

  // Counter table with per-entry valid bits
  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [CELLS-1:0]      vld_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  rvld_r;
  logic [COUNT_BITS-1:0] rd_eff;

  // Captured word
  logic [KIND_W-1:0] kind_r;
  logic [LBL_W-1:0]  t_r, p_r;
  logic              rng_r;
  logic [ADDR_W-1:0] addr_r;

  // Accumulated state
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] correct_r, correct_nxt;
  logic [SPAN_W-1:0]     span_r, span_nxt;

  // Result and divider
  logic [COUNT_BITS-1:0] res_cnt_r, res_cnt_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [PROD_W-1:0]     rem_r, dsr_r;
  logic [ACC_W-1:0]      quo_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_cnt_r, out_tot_r;
  logic [ACC_W-1:0]      out_acc_r;
  logic [SPAN_OUT_W-1:0] out_span_r;
  logic [STATUS_W-1:0]   out_st_r;

  logic              in_rng;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en, clr;
  logic [LBL_W-1:0]  hi;
  logic [SPAN_W-1:0] hi1;
  logic [PROD_W-1:0] corr_w, scale_w;

  // Decode incoming word
  assign in_rng  = (RNG_W'(in_truth) < RNG_W'(NUM_CLASSES)) &&
                   (RNG_W'(in_pred) < RNG_W'(NUM_CLASSES));
  assign rd_addr = ADDR_W'(in_truth[LBL_W-1:0] * NUM_CLASSES + in_pred[LBL_W-1:0]);

  // Capture word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      t_r    <= in_truth[LBL_W-1:0];
      p_r    <= in_pred[LBL_W-1:0];
      rng_r  <= in_rng;
      addr_r <= rd_addr;
    end
  end

  // Table read and write-back
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[addr_r] <= sat_inc(rd_eff);
    end
  end

  // Valid bits: cleared by reset and by a clear word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rvld_r <= vld_r[rd_addr];
      end
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

  assign rd_eff = rvld_r ? rdata_r : '0;
  assign hi     = (t_r > p_r) ? t_r : p_r;
  assign hi1    = SPAN_W'(hi) + 1'b1;

  // Execute the captured word
  always_comb begin
    wr_en       = 1'b0;
    clr         = 1'b0;
    total_nxt   = total_r;
    correct_nxt = correct_r;
    span_nxt    = span_r;
    res_cnt_nxt = '0;
    res_st_nxt  = ST_OK;
    if (cmd.exec) begin
      unique case (kind_r)
        KIND_SAMPLE: begin
          if (rng_r) begin
            wr_en     = 1'b1;
            total_nxt = sat_inc(total_r);
            if (t_r == p_r) begin
              correct_nxt = sat_inc(correct_r);
            end
            if (hi1 > span_r) begin
              span_nxt = hi1;
            end
          end else begin
            res_st_nxt = ST_RANGE;
          end
        end
        KIND_READ: begin
          if (rng_r) begin
            res_cnt_nxt = rd_eff;
          end else begin
            res_st_nxt = ST_RANGE;
          end
        end
        KIND_SUMMARY: begin
          res_cnt_nxt = correct_r;
          if (total_r == '0) begin
            res_st_nxt = ST_EMPTY;
          end
        end
        KIND_CLEAR: begin
          clr         = 1'b1;
          total_nxt   = '0;
          correct_nxt = '0;
          span_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  // Accumulated counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      correct_r <= '0;
      span_r    <= '0;
    end else begin
      total_r   <= total_nxt;
      correct_r <= correct_nxt;
      span_r    <= span_nxt;
    end
  end

  assign corr_w  = PROD_W'(correct_r);
  assign scale_w = PROD_W'(ACC_SCALE);

  // Result fields and accuracy division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_cnt_r <= res_cnt_nxt;
      res_st_r  <= res_st_nxt;
      quo_r     <= '0;
    end
    if (cmd.mul) begin
      rem_r <= corr_w * scale_w;
      dsr_r <= PROD_W'(total_r) << (ACC_W - 1);
    end
    if (cmd.div_step) begin
      if (rem_r >= dsr_r) begin
        rem_r <= rem_r - dsr_r;
        quo_r <= {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[ACC_W-2:0], 1'b0};
      end
      dsr_r <= dsr_r >> 1;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_cnt_r  <= clip_out(res_cnt_r);
      out_tot_r  <= clip_out(total_r);
      out_acc_r  <= quo_r;
      out_span_r <= SPAN_OUT_W'(span_r);
      out_st_r   <= res_st_r;
    end
  end

  assign out_word.valid               = out_valid_r;
  assign out_word.count_value         = out_cnt_r;
  assign out_word.total_samples       = out_tot_r;
  assign out_word.accuracy_hundredths = out_acc_r;
  assign out_word.classes_seen        = out_span_r;
  assign out_word.status              = out_st_r;

  assign sts.kind     = kind_r;
  assign sts.nonempty = (total_r != '0);
  assign sts.out_free = !out_valid_r || out_word.ready;

  // Correct count never exceeds the total
  assert property (@(posedge clk) disable iff (!rst_n)
    correct_r <= total_r)
    else $error("correct count exceeds total");

  // Accuracy never exceeds one hundred percent
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_acc_r <= ACC_W'(ACC_SCALE))
    else $error("accuracy above full scale");

  // Class span stays within the table
  assert property (@(posedge clk) disable iff (!rst_n)
    span_r <= SPAN_W'(NUM_CLASSES))
    else $error("class span beyond table size");

endmodule

/* design/confusion_matrix_accumulator.sv */
// Confusion matrix accumulator. Counts (truth, predicted) label pairs in a
// 16 x 16 table of saturating 32-bit counters held in a single-port RAM with
// per-entry valid bits, so reset and a clear word need no clearing pass.
// One word is worked on at a time and every word returns exactly one result
// word. A sample, cell read or clear goes through acceptance with the RAM
// read, read-modify-write, and load of the output register once it is free,
// before the input is free again; a summary with samples adds the scaling
// multiply and the restoring divider, which forms accuracy one quotient bit
// per cycle, ahead of that load. The output register lets the next word be
// accepted while a result still waits to be taken.
// Depends on cma_pkg, cma_if, cma_ctrl and cma_dp.
module confusion_matrix_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  cma_in_if.sink    in_word,
  cma_out_if.source out_word
);
  import cma_pkg::*;

  cma_cmd_t cmd;
  cma_sts_t sts;
  logic     in_ready;

  // Sequencer
  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, counters, divider and output register
  cma_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_kind  (in_word.kind),
    .in_truth (in_word.truth_label),
    .in_pred  (in_word.predicted_label),
    .out_word (out_word)
  );

  assign in_word.ready = in_ready;

endmodule
